// ===== hdl/bcs_pkg.sv =====
// ----------------------------------------------------------------------------
// bcs_pkg
// Shared types, key codes and level grids of the bulb command sequencer.
// ----------------------------------------------------------------------------
package bcs_pkg;

	localparam int NUM_SEGS = 5;

	// command groups, in transmit order
	localparam logic [2:0] SEG_STATUS = 3'd0;
	localparam logic [2:0] SEG_MODE   = 3'd1;
	localparam logic [2:0] SEG_COLOUR = 3'd2;
	localparam logic [2:0] SEG_BRIGHT = 3'd3;
	localparam logic [2:0] SEG_TEMP   = 3'd4;

	// configuration register indexes
	localparam logic [1:0] CFG_ADDR_HIGH = 2'd0;
	localparam logic [1:0] CFG_ADDR_LOW  = 2'd1;
	localparam logic [1:0] CFG_BULB_KIND = 2'd2;

	// bulb kinds
	localparam logic [1:0] KIND_NONE  = 2'd0;
	localparam logic [1:0] KIND_WHITE = 2'd1;
	localparam logic [1:0] KIND_RGB   = 2'd2;

	// radio formats
	localparam logic [1:0] LINK_RGB   = 2'd1;
	localparam logic [1:0] LINK_WHITE = 2'd2;

	// white bulb button codes
	localparam logic [7:0] W_ON        = 8'h08;
	localparam logic [7:0] W_OFF       = 8'h0B;
	localparam logic [7:0] W_NIGHT     = 8'h18;
	localparam logic [7:0] W_WHITE     = 8'h08;
	localparam logic [7:0] W_FULL      = 8'h18;
	localparam logic [7:0] W_BRT_UP    = 8'h0C;
	localparam logic [7:0] W_BRT_DOWN  = 8'h04;
	localparam logic [7:0] W_WARMER    = 8'h0F;
	localparam logic [7:0] W_COOLER    = 8'h0E;
	localparam logic [7:0] W_COLOUR    = 8'h01;

	// rgb bulb key codes
	localparam logic [7:0] R_ON        = 8'h03;
	localparam logic [7:0] R_OFF       = 8'h04;
	localparam logic [7:0] R_WHITE     = 8'h13;
	localparam logic [7:0] R_COLOUR    = 8'h03;
	localparam logic [7:0] R_COLOUR_B  = 8'h0F;
	localparam logic [7:0] R_BRIGHT    = 8'h0E;
	localparam logic [7:0] R_BRT_BASE  = 8'd129;

	localparam logic [3:0] TEMP_MAX    = 4'd10;
	localparam logic [3:0] WHITE_TOP   = 4'd10;
	localparam logic [3:0] WHITE_OFF   = 4'd11;
	localparam logic [6:0] WHITE_FIRST = 7'd9;

	localparam logic [6:0] WHITE_GRID [11] = '{
		7'd9, 7'd18, 7'd27, 7'd36, 7'd45, 7'd54, 7'd63, 7'd72, 7'd81, 7'd90, 7'd100
	};
	localparam logic [6:0] COLOUR_GRID [26] = '{
		7'd4, 7'd8, 7'd12, 7'd15, 7'd19, 7'd23, 7'd27, 7'd31, 7'd35, 7'd39, 7'd42,
		7'd46, 7'd50, 7'd54, 7'd58, 7'd62, 7'd65, 7'd69, 7'd73, 7'd77, 7'd81, 7'd85,
		7'd88, 7'd92, 7'd96, 7'd100
	};

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PLAN,
		ST_RUN
	} seq_state_t;

	typedef struct packed {
		logic       on;
		logic       mode;
		logic [6:0] level;
		logic [7:0] hue;
		logic [3:0] temp;
	} lamp_t;

	typedef struct packed {
		logic [3:0] cnt;
		logic [7:0] key;
		logic [7:0] btn;
		logic       bv;
		logic [7:0] col;
		logic       cv;
	} seg_t;

	typedef struct packed {
		logic [1:0]                link;
		logic [6:0]                level;
		seg_t [NUM_SEGS-1:0]       segs;
	} plan_t;

	function automatic logic [3:0] white_index(input logic [6:0] v);
		logic [3:0] idx;
		idx = WHITE_TOP;
		for (int i = 10; i >= 0; i--) begin
			if (v <= WHITE_GRID[i]) begin
				idx = 4'(i);
			end
		end
		return idx;
	endfunction

	function automatic logic [4:0] colour_index(input logic [6:0] v);
		logic [4:0] idx;
		idx = 5'd25;
		for (int i = 25; i >= 0; i--) begin
			if (v <= COLOUR_GRID[i]) begin
				idx = 5'(i);
			end
		end
		return idx;
	endfunction

	function automatic logic [3:0] white_pos(input logic [6:0] v);
		logic [3:0] pos;
		pos = WHITE_OFF;
		for (int i = 0; i < 11; i++) begin
			if (v == WHITE_GRID[i]) begin
				pos = 4'(i);
			end
		end
		return pos;
	endfunction

endpackage

// ===== hdl/bcs_plan.sv =====
// ----------------------------------------------------------------------------
// bcs_plan
// Works out the command groups that move the bulb from its stored setting
// to the requested one: count, key, button and colour of each group.
// ----------------------------------------------------------------------------
module bcs_plan (
	input  bcs_pkg::lamp_t  req,
	input  bcs_pkg::lamp_t  prev,
	input  logic [1:0]      kind,
	output bcs_pkg::plan_t  plan
);
	import bcs_pkg::*;

	logic [3:0] idx_w;
	logic [4:0] idx_c;
	logic [6:0] q_w;
	logic [6:0] q_c;
	logic [6:0] old_b;
	logic [3:0] np;
	logic [3:0] op;
	logic       force_mode;

	always_comb begin
		plan       = '0;
		idx_w      = white_index(req.level);
		idx_c      = colour_index(req.level);
		q_w        = WHITE_GRID[idx_w];
		q_c        = COLOUR_GRID[idx_c];
		old_b      = prev.level;
		np         = '0;
		op         = '0;
		force_mode = 1'b0;
		plan.level = (kind == KIND_WHITE) ? q_w : q_c;
		plan.link  = (kind == KIND_WHITE) ? LINK_WHITE : LINK_RGB;
		case (kind)
			KIND_WHITE: begin
				for (int s = 0; s < NUM_SEGS; s++) begin
					plan.segs[s].bv  = 1'b1;
					plan.segs[s].col = W_COLOUR;
					plan.segs[s].cv  = 1'b1;
				end
				if (req.on != prev.on) begin
					plan.segs[SEG_STATUS].cnt = 4'd1;
					plan.segs[SEG_STATUS].btn = req.on ? W_ON : W_OFF;
					if (req.on) begin
						old_b = WHITE_FIRST;
					end
				end
				if (req.on) begin
					if (req.mode != prev.mode) begin
						plan.segs[SEG_MODE].cnt = 4'd1;
						plan.segs[SEG_MODE].btn = req.mode ? W_NIGHT : W_WHITE;
						old_b = WHITE_FIRST;
					end
					if (q_w != old_b) begin
						np = idx_w;
						op = white_pos(old_b);
						if (np > op) begin
							if (np == WHITE_TOP) begin
								plan.segs[SEG_BRIGHT].cnt = 4'd1;
								plan.segs[SEG_BRIGHT].btn = W_FULL;
							end else begin
								plan.segs[SEG_BRIGHT].cnt = np - op + 4'd1;
								plan.segs[SEG_BRIGHT].btn = W_BRT_UP;
							end
						end else begin
							plan.segs[SEG_BRIGHT].cnt = op - np + 4'd1;
							plan.segs[SEG_BRIGHT].btn = W_BRT_DOWN;
						end
					end
					if (req.temp != prev.temp) begin
						if (req.temp > prev.temp) begin
							plan.segs[SEG_TEMP].cnt = req.temp - prev.temp + 4'd1;
							plan.segs[SEG_TEMP].btn = W_WARMER;
						end else begin
							plan.segs[SEG_TEMP].cnt = prev.temp - req.temp + 4'd1;
							plan.segs[SEG_TEMP].btn = W_COOLER;
						end
					end
				end
			end
			KIND_RGB: begin
				if (req.on != prev.on) begin
					plan.segs[SEG_STATUS].cnt = 4'd1;
					plan.segs[SEG_STATUS].key = req.on ? R_ON : R_OFF;
					if (req.on) begin
						force_mode = 1'b1;
						old_b      = '0;
					end
				end
				if (req.on) begin
					if (force_mode || (req.mode != prev.mode)) begin
						plan.segs[SEG_MODE].cnt = 4'd1;
						plan.segs[SEG_MODE].key = req.mode ? R_WHITE : R_COLOUR;
						plan.segs[SEG_MODE].col = prev.hue;
						plan.segs[SEG_MODE].cv  = 1'b1;
						if (!req.mode) begin
							old_b = '0;
						end
					end
					if (!req.mode && (req.hue != prev.hue)) begin
						plan.segs[SEG_COLOUR].cnt = 4'd2;
						plan.segs[SEG_COLOUR].key = R_COLOUR;
						plan.segs[SEG_COLOUR].col = req.hue;
						plan.segs[SEG_COLOUR].cv  = 1'b1;
					end
					if (q_c != old_b) begin
						plan.segs[SEG_BRIGHT].cnt = 4'd1;
						plan.segs[SEG_BRIGHT].key = R_BRIGHT;
						plan.segs[SEG_BRIGHT].btn = R_BRT_BASE - {idx_c, 3'b000};
						plan.segs[SEG_BRIGHT].bv  = 1'b1;
						plan.segs[SEG_BRIGHT].col = req.hue;
						plan.segs[SEG_BRIGHT].cv  = 1'b1;
					end
				end
			end
			default: begin
			end
		endcase
	end

endmodule

// ===== hdl/bulb_command_sequencer.sv =====
// ----------------------------------------------------------------------------
// bulb_command_sequencer
// Turns one requested lamp setting into the run of radio remote commands
// that moves the bulb there from its last setting.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready) takes one request word: status, mode,
// brightness, colour and temperature step. Output channel (out_valid/
// out_ready) gives one command word per handshake; last marks the final
// command of a request. A request may give no command at all.
// Configuration: cfg_wr_en writes cfg_wdata to register cfg_idx. The user must
// write only while no request is in progress; the block does not enforce it.
// Only the bulb kind changes the commands sent.
// Timing: in_ready is high only in idle. After acceptance the plan state
// plans the run, then one command per cycle leaves through the output
// register unless the receiver stalls, with a skip step past each command
// group ahead of the last one used.
// A stalled receiver holds the current word and the sequencer waits; the
// next request can be taken while the last word still waits.
// Reset clears the stored setting, the transmission number and the bulb
// kind; no command is pending after reset.
// ----------------------------------------------------------------------------
module bulb_command_sequencer (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic [1:0] cfg_idx,
	input  logic [7:0] cfg_wdata,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       lamp_on,
	input  logic       colour_mode,
	input  logic [6:0] brightness_pct,
	input  logic [7:0] hue_code,
	input  logic [3:0] temp_step,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [1:0] link_type,
	output logic [7:0] key_byte,
	output logic [7:0] sequence_res,
	output logic [7:0] button_byte,
	output logic       button_valid,
	output logic [7:0] colour_byte,
	output logic       colour_valid,
	output logic       last
);
	import bcs_pkg::*;

	seq_state_t state_q, state_d;
	lamp_t      req_q;
	lamp_t      prev_q;
	logic [1:0] kind_q;
	logic [7:0] tx_q;
	logic [7:0] tx_next;
	plan_t      plan;
	seg_t       segs_q [NUM_SEGS];
	logic [1:0] link_q;
	logic [2:0] cur_seg_q;
	logic [4:0] rem_q;
	logic [4:0] total;
	seg_t       cur;
	logic       slot_free;
	logic       emit;
	logic       skip;
	logic       accept;
	logic [7:0] cur_key;

	logic       out_valid_q;
	logic [1:0] link_type_q;
	logic [7:0] key_byte_q;
	logic [7:0] sequence_res_q;
	logic [7:0] button_byte_q;
	logic       button_valid_q;
	logic [7:0] colour_byte_q;
	logic       colour_valid_q;
	logic       last_q;

	bcs_plan u_plan (
		.req  (req_q),
		.prev (prev_q),
		.kind (kind_q),
		.plan (plan)
	);

	always_comb begin
		total = '0;
		for (int s = 0; s < NUM_SEGS; s++) begin
			total = total + 5'(plan.segs[s].cnt);
		end
	end

	// address bytes belong to the radio framing and are not kept here
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q <= KIND_NONE;
		end else if (cfg_wr_en) begin
			case (cfg_idx)
				CFG_BULB_KIND: kind_q <= cfg_wdata[1:0];
				CFG_ADDR_HIGH, CFG_ADDR_LOW: kind_q <= kind_q;
				default: kind_q <= kind_q;
			endcase
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_PLAN;
				end
			end
			ST_PLAN: begin
				state_d = (total == '0) ? ST_IDLE : ST_RUN;
			end
			ST_RUN: begin
				if (emit && (rem_q == 5'd1)) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready  = (state_q == ST_IDLE);
		accept    = in_valid && in_ready;
		cur       = segs_q[cur_seg_q];
		slot_free = !out_valid_q || out_ready;
		emit      = (state_q == ST_RUN) && (cur.cnt != '0) && slot_free;
		skip      = (state_q == ST_RUN) && (cur.cnt == '0);
		tx_next   = tx_q + 8'd1;
		if (link_q == LINK_WHITE) begin
			cur_key = ~tx_next;
		end else if ((cur_seg_q == SEG_COLOUR) && (cur.cnt == 4'd1)) begin
			cur_key = R_COLOUR_B;
		end else begin
			cur_key = cur.key;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			prev_q    <= '0;
			tx_q      <= '0;
			rem_q     <= '0;
			cur_seg_q <= SEG_STATUS;
		end else begin
			state_q <= state_d;
			if (state_q == ST_PLAN) begin
				prev_q.on    <= req_q.on;
				prev_q.mode  <= req_q.mode;
				prev_q.level <= plan.level;
				prev_q.hue   <= req_q.hue;
				prev_q.temp  <= req_q.temp;
				rem_q        <= total;
				cur_seg_q    <= SEG_STATUS;
			end else if (emit) begin
				tx_q  <= tx_next;
				rem_q <= rem_q - 5'd1;
			end else if (skip) begin
				cur_seg_q <= cur_seg_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q.on    <= lamp_on;
			req_q.mode  <= colour_mode;
			req_q.level <= brightness_pct;
			req_q.hue   <= hue_code;
			req_q.temp  <= (temp_step > TEMP_MAX) ? TEMP_MAX : temp_step;
		end
		if (state_q == ST_PLAN) begin
			link_q <= plan.link;
			for (int s = 0; s < NUM_SEGS; s++) begin
				segs_q[s] <= plan.segs[s];
			end
		end else if (emit) begin
			segs_q[cur_seg_q].cnt <= cur.cnt - 4'd1;
		end
	end

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			link_type_q    <= link_q;
			key_byte_q     <= cur_key;
			sequence_res_q <= tx_next;
			button_byte_q  <= cur.btn;
			button_valid_q <= cur.bv;
			colour_byte_q  <= cur.col;
			colour_valid_q <= cur.cv;
			last_q         <= (rem_q == 5'd1);
		end
	end

	assign out_valid    = out_valid_q;
	assign link_type    = link_type_q;
	assign key_byte     = key_byte_q;
	assign sequence_res = sequence_res_q;
	assign button_byte  = button_byte_q;
	assign button_valid = button_valid_q;
	assign colour_byte  = colour_byte_q;
	assign colour_valid = colour_valid_q;
	assign last         = last_q;

`ifndef SYNTHESIS
	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (rem_q == '0))
		else $error("commands left over in idle");
	a_run_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) |-> (rem_q != '0))
		else $error("sequencer running with nothing to send");
	a_tx_step: assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> (tx_q == $past(tx_next)) && (sequence_res == tx_q))
		else $error("transmission number out of step");
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && (rem_q == 5'd1)) |=> (state_q == ST_IDLE) && last)
		else $error("final word not marked last");
`endif

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the bulb command sequencer. A table of directed
// requests is walked first, then phases of random requests under different
// bulb kinds, addresses and idle patterns. Every accepted request is run
// through a local model of the lamp state, and each command word coming out
// is compared field by field with the oldest predicted word.
// ----------------------------------------------------------------------------
module tb_top;

	import bcs_pkg::*;

	localparam int LIMIT_CYCLES  = 500000;
	localparam int SETTLE_CYCLES = 40;
	localparam int MAX_CMDS      = 24;
	localparam int RAND_PHASES   = 8;
	localparam int PHASE_WORDS   = 46;
	localparam int NUM_DIR       = 23;

	localparam logic [1:0] KIND_SPARE = 2'd3;
	localparam logic [1:0] CFG_SPARE  = 2'd3;

	localparam logic [6:0] COLOUR_LEVELS [26] = '{
		7'd4, 7'd8, 7'd12, 7'd15, 7'd19, 7'd23, 7'd27, 7'd31, 7'd35, 7'd39, 7'd42,
		7'd46, 7'd50, 7'd54, 7'd58, 7'd62, 7'd65, 7'd69, 7'd73, 7'd77, 7'd81, 7'd85,
		7'd88, 7'd92, 7'd96, 7'd100
	};

	localparam int GAP_PCT   [4] = '{0, 52, 0, 16};
	localparam int STALL_PCT [4] = '{0, 0, 52, 16};

	localparam logic [1:0] PHASE_KIND [RAND_PHASES] = '{
		KIND_WHITE, KIND_RGB, KIND_WHITE, KIND_RGB, KIND_NONE, KIND_RGB, KIND_WHITE, KIND_SPARE
	};

	typedef struct packed {
		logic [1:0] link;
		logic [7:0] key;
		logic [7:0] seq;
		logic [7:0] btn;
		logic       bv;
		logic [7:0] col;
		logic       cv;
		logic       last;
	} cmd_t;

	// one request; typed rows carry their own expectation (none or one word)
	typedef struct packed {
		logic [1:0] kind;
		logic       on;
		logic       mode;
		logic [6:0] pct;
		logic [7:0] hue;
		logic [3:0] ts;
		logic       typed;
		logic       one_cmd;
		logic [1:0] link;
		logic [7:0] key;
		logic [7:0] btn;
		logic       bv;
		logic [7:0] col;
		logic       cv;
	} lamp_req_t;

	localparam lamp_req_t DIR_ROWS [NUM_DIR] = '{
		'{KIND_NONE,  1'b1, 1'b1, 7'd100, 8'd255, 4'd10, 1'b1, 1'b0, 2'd0, 8'd0, 8'd0, 1'b0, 8'd0, 1'b0},
		'{KIND_NONE,  1'b0, 1'b0, 7'd0,   8'd0,   4'd0,  1'b1, 1'b0, 2'd0, 8'd0, 8'd0, 1'b0, 8'd0, 1'b0},
		'{KIND_RGB,   1'b1, 1'b0, 7'd0,   8'd0,   4'd0,  1'b0, 1'b0, 2'd0, 8'd0, 8'd0, 1'b0, 8'd0, 1'b0},
		'{KIND_RGB,   1'b1, 1'b0, 7'd127, 8'd255, 4'd15, 1'b0, 1'b0, 2'd0, 8'd0, 8'd0, 1'b0, 8'd0, 1'b0},
		'{KIND_RGB,   1'b0, 1'b0, 7'd127, 8'd255, 4'd15, 1'b1, 1'b1, LINK_RGB, R_OFF,
			8'd0, 1'b0, 8'd0, 1'b0},
		'{KIND_RGB,   1'b0, 1'b1, 7'd3,   8'd200, 4'd0,  1'b1, 1'b0, 2'd0, 8'd0, 8'd0, 1'b0, 8'd0, 1'b0},
		'{KIND_RGB,   1'b1, 1'b1, 7'd50,  8'd77,  4'd3,  1'b0, 1'b0, 2'd0, 8'd0, 8'd0, 1'b0, 8'd0, 1'b0},
		'{KIND_RGB,   1'b1, 1'b1, 7'd50,  8'd77,  4'd3,  1'b1, 1'b0, 2'd0, 8'd0, 8'd0, 1'b0, 8'd0, 1'b0},
		'{KIND_RGB,   1'b1, 1'b0, 7'd50,  8'd77,  4'd3,  1'b0, 1'b0, 2'd0, 8'd0, 8'd0, 1'b0, 8'd0, 1'b0},
		'{KIND_RGB,   1'b1, 1'b0, 7'd50,  8'd78,  4'd3,  1'b0, 1'b0, 2'd0, 8'd0, 8'd0, 1'b0, 8'd0, 1'b0},
		'{KIND_RGB,   1'b1, 1'b1, 7'd49,  8'd78,  4'd3,  1'b0, 1'b0, 2'd0, 8'd0, 8'd0, 1'b0, 8'd0, 1'b0},
		'{KIND_SPARE, 1'b1, 1'b0, 7'd0,   8'd0,   4'd0,  1'b1, 1'b0, 2'd0, 8'd0, 8'd0, 1'b0, 8'd0, 1'b0},
		'{KIND_WHITE, 1'b1, 1'b0, 7'd0,   8'd0,   4'd0,  1'b0, 1'b0, 2'd0, 8'd0, 8'd0, 1'b0, 8'd0, 1'b0},
		'{KIND_WHITE, 1'b1, 1'b0, 7'd100, 8'd0,   4'd10, 1'b0, 1'b0, 2'd0, 8'd0, 8'd0, 1'b0, 8'd0, 1'b0},
		'{KIND_WHITE, 1'b1, 1'b0, 7'd127, 8'd0,   4'd15, 1'b1, 1'b0, 2'd0, 8'd0, 8'd0, 1'b0, 8'd0, 1'b0},
		'{KIND_WHITE, 1'b1, 1'b0, 7'd0,   8'd0,   4'd0,  1'b0, 1'b0, 2'd0, 8'd0, 8'd0, 1'b0, 8'd0, 1'b0},
		'{KIND_WHITE, 1'b1, 1'b1, 7'd90,  8'd0,   4'd0,  1'b0, 1'b0, 2'd0, 8'd0, 8'd0, 1'b0, 8'd0, 1'b0},
		'{KIND_WHITE, 1'b0, 1'b1, 7'd90,  8'd0,   4'd0,  1'b1, 1'b1, LINK_WHITE, 8'd0,
			W_OFF, 1'b1, W_COLOUR, 1'b1},
		'{KIND_WHITE, 1'b1, 1'b1, 7'd90,  8'd0,   4'd0,  1'b0, 1'b0, 2'd0, 8'd0, 8'd0, 1'b0, 8'd0, 1'b0},
		'{KIND_WHITE, 1'b1, 1'b0, 7'd45,  8'd0,   4'd5,  1'b0, 1'b0, 2'd0, 8'd0, 8'd0, 1'b0, 8'd0, 1'b0},
		'{KIND_RGB,   1'b1, 1'b0, 7'd100, 8'd0,   4'd5,  1'b0, 1'b0, 2'd0, 8'd0, 8'd0, 1'b0, 8'd0, 1'b0},
		'{KIND_RGB,   1'b1, 1'b0, 7'd1,   8'd0,   4'd0,  1'b0, 1'b0, 2'd0, 8'd0, 8'd0, 1'b0, 8'd0, 1'b0},
		'{KIND_RGB,   1'b0, 1'b0, 7'd0,   8'd0,   4'd0,  1'b1, 1'b1, LINK_RGB, R_OFF,
			8'd0, 1'b0, 8'd0, 1'b0}
	};

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_wr_en = 1'b0;
	logic [1:0] cfg_idx = 2'd0;
	logic [7:0] cfg_wdata = 8'd0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic       lamp_on = 1'b0;
	logic       colour_mode = 1'b0;
	logic [6:0] brightness_pct = 7'd0;
	logic [7:0] hue_code = 8'd0;
	logic [3:0] temp_step = 4'd0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [1:0] link_type;
	logic [7:0] key_byte;
	logic [7:0] sequence_res;
	logic [7:0] button_byte;
	logic       button_valid;
	logic [7:0] colour_byte;
	logic       colour_valid;
	logic       last;

	// mirror of the registers and the stored lamp setting
	logic [7:0] addr_high_q = 8'd0;
	logic [7:0] addr_low_q  = 8'd0;
	logic [1:0] kind_q      = KIND_NONE;
	logic       last_on     = 1'b0;
	logic       last_mode   = 1'b0;
	logic [6:0] last_level  = 7'd0;
	logic [7:0] last_hue    = 8'd0;
	logic [3:0] last_temp   = 4'd0;
	logic [7:0] tx_count    = 8'd0;

	cmd_t       run_cmds [$];
	cmd_t       pending_cmds [$];
	lamp_req_t  prev_req;
	int         tx_gap_pct = 0;
	int         rx_stall_pct = 0;
	int         errors = 0;
	int         cycles = 0;

	bulb_command_sequencer i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_idx        (cfg_idx),
		.cfg_wdata      (cfg_wdata),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.lamp_on        (lamp_on),
		.colour_mode    (colour_mode),
		.brightness_pct (brightness_pct),
		.hue_code       (hue_code),
		.temp_step      (temp_step),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.link_type      (link_type),
		.key_byte       (key_byte),
		.sequence_res   (sequence_res),
		.button_byte    (button_byte),
		.button_valid   (button_valid),
		.colour_byte    (colour_byte),
		.colour_valid   (colour_valid),
		.last           (last)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic logic [6:0] white_level(input int i);
		return (i == 10) ? 7'd100 : 7'(9 * (i + 1));
	endfunction

	function automatic int white_step(input logic [6:0] v);
		for (int i = 0; i < 11; i++) begin
			if (v <= white_level(i)) begin
				return i;
			end
		end
		return 10;
	endfunction

	function automatic int white_slot(input logic [6:0] v);
		for (int i = 0; i < 11; i++) begin
			if (v == white_level(i)) begin
				return i;
			end
		end
		return 11;
	endfunction

	function automatic int colour_step(input logic [6:0] v);
		for (int i = 0; i < 26; i++) begin
			if (v <= COLOUR_LEVELS[i]) begin
				return i;
			end
		end
		return 25;
	endfunction

	task automatic white_cmd(input logic [7:0] code);
		tx_count = tx_count + 8'd1;
		if (run_cmds.size() < MAX_CMDS) begin
			run_cmds.push_back('{LINK_WHITE, 8'hFF - tx_count, tx_count, code, 1'b1,
				W_COLOUR, 1'b1, 1'b0});
		end
	endtask

	task automatic rgb_cmd(input logic [7:0] key, input logic [7:0] btn, input logic bv,
			input logic [7:0] col, input logic cv);
		tx_count = tx_count + 8'd1;
		if (run_cmds.size() < MAX_CMDS) begin
			run_cmds.push_back('{LINK_RGB, key, tx_count, btn, bv, col, cv, 1'b0});
		end
	endtask

	// commands that move the lamp from its stored setting to the requested one
	task automatic plan_commands(input logic on, input logic mode, input logic [6:0] pct,
			input logic [7:0] hue, input logic [3:0] ts);
		int         idx;
		int         old_pos;
		int         t_new;
		int         t_old;
		logic [6:0] lvl;
		logic [6:0] old_lvl;
		logic       forced;
		cmd_t       tail;
		run_cmds.delete();
		t_new = (ts > TEMP_MAX) ? int'(TEMP_MAX) : int'(ts);
		t_old = int'(last_temp);
		old_lvl = last_level;
		if (kind_q == KIND_WHITE) begin
			idx = white_step(pct);
			lvl = white_level(idx);
			if (on != last_on) begin
				white_cmd(on ? W_ON : W_OFF);
				if (on) begin
					old_lvl = WHITE_FIRST;
				end
			end
			if (on) begin
				if (mode != last_mode) begin
					white_cmd(mode ? W_NIGHT : W_WHITE);
					old_lvl = WHITE_FIRST;
				end
				if (lvl != old_lvl) begin
					old_pos = white_slot(old_lvl);
					if (idx > old_pos) begin
						if (idx == 10) begin
							white_cmd(W_FULL);
						end else begin
							repeat (idx - old_pos + 1) white_cmd(W_BRT_UP);
						end
					end else begin
						repeat (old_pos - idx + 1) white_cmd(W_BRT_DOWN);
					end
				end
				if (t_new > t_old) begin
					repeat (t_new - t_old + 1) white_cmd(W_WARMER);
				end else if (t_new < t_old) begin
					repeat (t_old - t_new + 1) white_cmd(W_COOLER);
				end
			end
		end else begin
			idx = colour_step(pct);
			lvl = COLOUR_LEVELS[idx];
			if (kind_q == KIND_RGB) begin
				forced = 1'b0;
				if (on != last_on) begin
					rgb_cmd(on ? R_ON : R_OFF, 8'd0, 1'b0, 8'd0, 1'b0);
					if (on) begin
						forced = 1'b1;
						old_lvl = 7'd0;
					end
				end
				if (on) begin
					if (forced || mode != last_mode) begin
						rgb_cmd(mode ? R_WHITE : R_COLOUR, 8'd0, 1'b0, last_hue, 1'b1);
						if (!mode) begin
							old_lvl = 7'd0;
						end
					end
					if (!mode && hue != last_hue) begin
						rgb_cmd(R_COLOUR, 8'd0, 1'b0, hue, 1'b1);
						rgb_cmd(R_COLOUR_B, 8'd0, 1'b0, hue, 1'b1);
					end
					if (lvl != old_lvl) begin
						rgb_cmd(R_BRIGHT, R_BRT_BASE - 8'(8 * idx), 1'b1, hue, 1'b1);
					end
				end
			end
		end
		if (run_cmds.size() > 0) begin
			tail = run_cmds.pop_back();
			tail.last = 1'b1;
			run_cmds.push_back(tail);
		end
		last_on    = on;
		last_mode  = mode;
		last_level = lvl;
		last_hue   = hue;
		last_temp  = 4'(t_new);
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_cmds.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [1:0] idx, input logic [7:0] data);
		cfg_wr_en <= 1'b1;
		cfg_idx   <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		case (idx)
			CFG_ADDR_HIGH: addr_high_q = data;
			CFG_ADDR_LOW:  addr_low_q = data;
			CFG_BULB_KIND: kind_q = data[1:0];
			default: ;
		endcase
		cfg_wr_en <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_word(input lamp_req_t r);
		logic [7:0] seq;
		logic [7:0] key;
		while ($urandom_range(99) < tx_gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid       <= 1'b1;
		lamp_on        <= r.on;
		colour_mode    <= r.mode;
		brightness_pct <= r.pct;
		hue_code       <= r.hue;
		temp_step      <= r.ts;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		seq = tx_count + 8'd1;
		plan_commands(r.on, r.mode, r.pct, r.hue, r.ts);
		if (r.typed) begin
			run_cmds.delete();
			if (r.one_cmd) begin
				key = (r.link == LINK_WHITE) ? 8'hFF - seq : r.key;
				run_cmds.push_back('{r.link, key, seq, r.btn, r.bv, r.col, r.cv, 1'b1});
			end
		end
		foreach (run_cmds[i]) pending_cmds.push_back(run_cmds[i]);
	endtask

	function automatic lamp_req_t random_req(input lamp_req_t p);
		lamp_req_t r;
		int        roll;
		r = p;
		r.typed = 1'b0;
		if ($urandom_range(99) < 5) begin
			return r;
		end
		r.on = ($urandom_range(99) < 85) ? 1'b1 : 1'b0;
		if ($urandom_range(99) < 30) begin
			r.mode = 1'($urandom_range(1));
		end
		roll = $urandom_range(99);
		if (roll < 10) begin
			r.pct = 7'($urandom_range(127, 101));
		end else if (roll < 20) begin
			r.pct = ($urandom_range(1) != 0) ? 7'd100 : 7'd0;
		end else begin
			r.pct = 7'($urandom_range(100));
		end
		if ($urandom_range(99) < 50) begin
			r.hue = 8'($urandom_range(255));
		end
		roll = $urandom_range(99);
		if (roll < 10) begin
			r.ts = 4'($urandom_range(15, 11));
		end else if (roll < 60) begin
			r.ts = 4'($urandom_range(10));
		end
		return r;
	endfunction

	task automatic check_field(input string name, input int unsigned exp_v,
			input int unsigned act_v);
		if (exp_v != act_v) begin
			$display("%0t: %s expected %0d, got %0d", $time, name, exp_v, act_v);
			errors++;
		end
	endtask

	always @(posedge clk) begin : rx_side
		cmd_t exp_cmd;
		if (arst_n && out_valid && out_ready) begin
			if (pending_cmds.size() == 0) begin
				$display("%0t: command word with nothing expected, key %0d seq %0d",
					$time, key_byte, sequence_res);
				errors++;
			end else begin
				exp_cmd = pending_cmds.pop_front();
				check_field("link_type", exp_cmd.link, link_type);
				check_field("key_byte", exp_cmd.key, key_byte);
				check_field("sequence_res", exp_cmd.seq, sequence_res);
				check_field("button_byte", exp_cmd.btn, button_byte);
				check_field("button_valid", exp_cmd.bv, button_valid);
				check_field("colour_byte", exp_cmd.col, colour_byte);
				check_field("colour_valid", exp_cmd.cv, colour_valid);
				check_field("last", exp_cmd.last, last);
			end
		end
		out_ready <= ($urandom_range(99) >= rx_stall_pct);
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("FAIL");
			$finish;
		end
	end

	initial begin : stim
		lamp_req_t  r;
		logic [7:0] ah;
		logic [7:0] al;
		logic [7:0] kind_data;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed table
		for (int i = 0; i < NUM_DIR; i++) begin
			r = DIR_ROWS[i];
			if (r.kind != kind_q) begin
				wait_idle();
				cfg_write(CFG_BULB_KIND, {6'd0, r.kind});
			end
			send_word(r);
		end
		prev_req = DIR_ROWS[NUM_DIR - 1];

		// random phases
		for (int p = 0; p < RAND_PHASES; p++) begin
			wait_idle();
			tx_gap_pct   = GAP_PCT[p % 4];
			rx_stall_pct = STALL_PCT[p % 4];
			if (p == 0) begin
				ah = 8'd0;
				al = 8'd0;
			end else if (p == 1) begin
				ah = 8'd255;
				al = 8'd255;
			end else begin
				ah = 8'($urandom_range(255));
				al = 8'($urandom_range(255));
			end
			kind_data = (p % 2 == 1) ? {6'($urandom_range(63)), PHASE_KIND[p]}
				: {6'd0, PHASE_KIND[p]};
			cfg_write(CFG_ADDR_HIGH, ah);
			cfg_write(CFG_ADDR_LOW, al);
			cfg_write(CFG_BULB_KIND, kind_data);
			if (p == 3) begin
				cfg_write(CFG_SPARE, 8'($urandom_range(255)));
			end
			for (int k = 0; k < PHASE_WORDS; k++) begin
				if (k == PHASE_WORDS / 2 && p % 4 != 0) begin
					wait_idle();
				end
				r = random_req(prev_req);
				send_word(r);
				prev_req = r;
			end
		end

		wait_idle();
		if (errors == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
